// ----- rtl/core/motion_direction_looming_detector_top_macros.svh -----
// assertion macros for the motion direction and looming detector
`ifndef MOTION_DIRECTION_LOOMING_DETECTOR_TOP_MACROS_SVH
`define MOTION_DIRECTION_LOOMING_DETECTOR_TOP_MACROS_SVH
// implication checked at every edge outside reset
`define MDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/mdl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdl_pkg
// types and constants shared by the detector modules
// ----------------------------------------------------------------------------
package mdl_pkg;
  localparam int Detectors = 8;
  localparam int CoordW = 16;
  localparam int DeltaW = 17;
  localparam int FiltW  = 24;
  localparam int MotW   = 18;
  localparam int SqW    = 34;
  localparam int RootW  = 17;

  localparam logic [2:0] DirNone  = 3'd0;
  localparam logic [2:0] DirLeft  = 3'd1;
  localparam logic [2:0] DirRight = 3'd2;
  localparam logic [2:0] DirUp    = 3'd3;
  localparam logic [2:0] DirDown  = 3'd4;

  localparam logic [1:0] RegAlpha  = 2'd0;
  localparam logic [1:0] RegThresh = 2'd1;
  localparam logic [1:0] RegMinCnt = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [FiltW-1:0] filtered_x;
    logic signed [FiltW-1:0] filtered_y;
    logic [2:0]              direction;
    logic                    looming;
    logic [MotW-1:0]         left_motion;
    logic [MotW-1:0]         right_motion;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage

// ----- rtl/core/motion_direction_looming_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_direction_looming_detector_top
// detector beats in, one frame result per Detectors beats
// ----------------------------------------------------------------------------
// sequence: detectors 0-3 hold the input while the serial square root runs
//   (2 bits a cycle), detectors 4-6 do not hold it; the result is valid after
//   the last beat of a frame once the filter multiply and the walk have run
// flow: one beat at a time; input also held while the filter and walk run
//   and while a result waits
// reset: rst_n synchronous, clears sums, filter and counters, loads config defaults
module motion_direction_looming_detector_top import mdl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
`include "motion_direction_looming_detector_top_macros.svh"
  localparam int IdxW = $clog2(Detectors);
  localparam int CntW = $clog2(Detectors + 1);
  localparam int ScW  = DeltaW + IdxW + 2;

  typedef enum logic [2:0] {SIdle, SRoot, SFilt, SWalk, SOut} state_t;
  state_t state_r;

  logic [15:0] alpha_r, thr_r;
  logic [3:0]  minc_r;
  logic [IdxW-1:0] k_r, w_r;
  logic signed [DeltaW-1:0] dx_mem [Detectors];
  logic signed [DeltaW-1:0] dy_mem [Detectors];
  logic [3:0]  sg_mem [Detectors];
  logic signed [19:0] sx_r, sy_r;
  logic signed [FiltW-1:0] fx_r, fy_r;
  logic [MotW-1:0] la_r, ra_r;
  logic [CntW-1:0] oc_r;
  logic [1:0]  fdone_r;
  logic        fstart_r;
  logic        rstart_r;
  out_beat_t   out_r;
  logic        out_v_r;
  logic [SqW-1:0] rad_r;

  logic signed [DeltaW-1:0] dx, dy;
  logic [SqW-1:0] rad;
  unit_ctl_t rctl, fxctl, fyctl;
  logic [RootW-1:0] root;
  logic signed [FiltW-1:0] fxo, fyo;
  logic in_acc, cfg_wr;
  logic signed [ScW-1:0] cx, cy, dot;
  logic [3:0] sg;
  logic [2:0] dir;
  logic signed [FiltW:0] ex, ey;
  logic [33:0] ax2, ay2;

  assign dx  = DeltaW'($signed({1'b0, in_data.end_x})) - DeltaW'($signed({1'b0, in_data.start_x}));
  assign dy  = DeltaW'($signed({1'b0, in_data.end_y})) - DeltaW'($signed({1'b0, in_data.start_y}));
  assign ax2 = 34'(dx * dx);
  assign ay2 = 34'(dy * dy);
  assign rad = ax2 + ay2;

  assign in_stall = (state_r != SIdle) || out_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  mdl_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(rstart_r), .radicand(rad_r),
    .ctl(rctl), .root(root));

  mdl_filter u_fx (.clk(clk), .rst_n(rst_n), .start(fstart_r), .alpha(alpha_r),
    .f_in(fx_r), .sum_in(sx_r), .ctl(fxctl), .f_out(fxo));
  mdl_filter u_fy (.clk(clk), .rst_n(rst_n), .start(fstart_r), .alpha(alpha_r),
    .f_in(fy_r), .sum_in(sy_r), .ctl(fyctl), .f_out(fyo));

  always_comb begin
    unique case (cfg_paddr[3:2])
      RegAlpha:  cfg_prdata = {16'd0, alpha_r};
      RegThresh: cfg_prdata = {16'd0, thr_r};
      RegMinCnt: cfg_prdata = {28'd0, minc_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // looming walk term, scaled by Detectors
  always_comb begin
    sg  = sg_mem[w_r];
    cx  = (ScW'(dx_mem[w_r]) <<< IdxW) - ScW'(sx_r);
    cy  = (ScW'(dy_mem[w_r]) <<< IdxW) - ScW'(sy_r);
    dot = '0;
    if (sg[1]) dot = sg[0] ? dot - cx : dot + cx;
    if (sg[3]) dot = sg[2] ? dot - cy : dot + cy;
  end

  always_comb begin
    ex = (FiltW+1)'(fx_r);
    ey = (FiltW+1)'(fy_r);
    if (ex == '0 && ey == '0) dir = DirRight;
    else if (ey < 0) begin
      if (ex < ey) dir = DirLeft;
      else if (ex < -ey) dir = DirUp;
      else dir = DirRight;
    end else begin
      if (ey < ex) dir = DirRight;
      else if (ey > -ex) dir = DirDown;
      else dir = DirLeft;
    end
  end

  always_ff @(posedge clk) begin
    rstart_r <= in_acc && (k_r < IdxW'(4));
    fstart_r <= in_acc && (k_r == IdxW'(Detectors - 1));
    if (in_acc) begin
      dx_mem[k_r] <= dx;
      dy_mem[k_r] <= dy;
      sg_mem[k_r] <= {in_data.start_y != 16'h8000, in_data.start_y < 16'h8000,
                      in_data.start_x != 16'h8000, in_data.start_x < 16'h8000};
      rad_r <= rad;
    end
    if (!rst_n) begin
      state_r <= SIdle;
      alpha_r <= 16'd45875;
      thr_r   <= 16'd33;
      minc_r  <= 4'd4;
      k_r <= '0; w_r <= '0;
      sx_r <= '0; sy_r <= '0; fx_r <= '0; fy_r <= '0;
      la_r <= '0; ra_r <= '0; oc_r <= '0; fdone_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          RegAlpha:  alpha_r <= cfg_pwdata[15:0];
          RegThresh: thr_r   <= cfg_pwdata[15:0];
          RegMinCnt: minc_r  <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      unique case (state_r)
        SIdle: if (in_acc) begin
          sx_r <= sx_r + 20'(dx);
          sy_r <= sy_r + 20'(dy);
          if (k_r < IdxW'(4)) begin
            state_r  <= SRoot;
          end else if (k_r == IdxW'(Detectors - 1)) begin
            fdone_r  <= '0;
            state_r  <= SFilt;
          end else k_r <= k_r + 1'b1;
        end
        SRoot: if (rctl.done) begin
          if (k_r < IdxW'(2)) la_r <= la_r + MotW'(root);
          else ra_r <= ra_r + MotW'(root);
          k_r <= k_r + 1'b1;
          state_r <= SIdle;
        end
        SFilt: begin
          if (fxctl.done) begin fx_r <= fxo; fdone_r[0] <= 1'b1; end
          if (fyctl.done) begin fy_r <= fyo; fdone_r[1] <= 1'b1; end
          if (fdone_r == 2'b11) begin
            w_r <= '0; oc_r <= '0;
            state_r <= SWalk;
          end
        end
        SWalk: begin
          if (dot > ($signed({1'b0, ScW'(thr_r)}) <<< IdxW)) oc_r <= oc_r + 1'b1;
          w_r <= w_r + 1'b1;
          if (w_r == IdxW'(Detectors - 1)) state_r <= SOut;
        end
        SOut: begin
          out_r.filtered_x   <= fx_r;
          out_r.filtered_y   <= fy_r;
          out_r.direction    <= (sx_r == '0 && sy_r == '0) ? DirNone : dir;
          out_r.looming      <= 8'(oc_r) >= 8'(minc_r);
          out_r.left_motion  <= la_r;
          out_r.right_motion <= ra_r;
          out_v_r <= 1'b1;
          k_r <= '0; sx_r <= '0; sy_r <= '0; la_r <= '0; ra_r <= '0;
          state_r <= SIdle;
        end
        default: state_r <= SIdle;
      endcase
    end
  end

  `MDL_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != SIdle, !in_acc, "beat taken while busy")
  `MDL_ASSERT_NXT(a_out_after_sout, clk, rst_n, state_r == SOut, out_v_r, "result not raised")
  `MDL_ASSERT_IMP(a_filters_lockstep, clk, rst_n, fxctl.done, fyctl.done, "filters out of step")
endmodule

// ----- rtl/core/mdl_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdl_isqrt
// digit-serial floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module mdl_isqrt import mdl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SqW-1:0]   radicand,
  output unit_ctl_t        ctl,
  output logic [RootW-1:0] root
);
  localparam int Steps = SqW / 2;
  logic [SqW-1:0]   rad_r, rad_nxt;
  logic [RootW+1:0] rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [RootW+1:0] trial, rem_sh;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[RootW-1:0], rad_r[SqW-1 -: 2]};
    trial    = {root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl  = '{start: start, busy: busy_r, done: done_r};
  assign root = root_r;
endmodule

// ----- rtl/core/mdl_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdl_filter
// serial-parallel alpha multiply, one alpha bit per cycle, adds sum_in, floor and saturate
// ----------------------------------------------------------------------------
module mdl_filter import mdl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [15:0]             alpha,
  input  logic signed [FiltW-1:0] f_in,
  input  logic signed [19:0]      sum_in,
  output unit_ctl_t               ctl,
  output logic signed [FiltW-1:0] f_out
);
  logic signed [41:0] acc_r, acc_nxt;
  logic [15:0]        al_r, al_nxt;
  logic signed [41:0] fsh_r, fsh_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [FiltW-1:0] res_r, res_nxt;
  logic signed [26:0] tot;

  always_comb begin
    acc_nxt  = acc_r;
    al_nxt   = al_r;
    fsh_nxt  = fsh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    tot      = 27'(acc_r >>> 16) + 27'(sum_in);
    if (start) begin
      acc_nxt  = '0;
      al_nxt   = alpha;
      fsh_nxt  = 42'(f_in);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (tot > 27'sd8388607) res_nxt = 24'sh7fffff;
        else if (tot < -27'sd8388608) res_nxt = 24'sh800000;
        else res_nxt = tot[FiltW-1:0];
      end else begin
        if (al_r[0]) acc_nxt = acc_r + fsh_r;
        al_nxt  = al_r >> 1;
        fsh_nxt = fsh_r <<< 1;
        cnt_nxt = cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    al_r  <= al_nxt;
    fsh_r <= fsh_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl   = '{start: start, busy: busy_r, done: done_r};
  assign f_out = res_r;
endmodule
